// ----- rtl/uyvbgr_pkg.sv -----
// Shared types and constants for the UYVY downscale to BGR unit.
package uyvbgr_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned SUM_W   = CHAN_W + 2;

    // byte lanes of a UYVY macropixel word
    localparam int unsigned LANE_U  = 0;
    localparam int unsigned LANE_Y0 = 1;
    localparam int unsigned LANE_V  = 2;
    localparam int unsigned LANE_Y1 = 3;

    localparam logic [CHAN_W:0] Y_OFFSET  = 9'd16;
    localparam logic [CHAN_W:0] UV_OFFSET = 9'd128;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // coefficients in thousandths
    localparam int unsigned MILLI_Y  = 1164;
    localparam int unsigned MILLI_VR = 1596;
    localparam int unsigned MILLI_VG = 813;
    localparam int unsigned MILLI_UG = 392;
    localparam int unsigned MILLI_UB = 2017;

    typedef enum logic [1:0] {
        PH_M0 = 2'd0,
        PH_M1 = 2'd1,
        PH_M2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CHAN_W-1:0] v;
        logic [CHAN_W-1:0] u;
        logic [CHAN_W-1:0] y;
    } yuv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } bgr_t;

endpackage

// ----- rtl/uyvbgr_convert.sv -----
// BT.601 fixed-point YUV to BGR conversion with floor and clamp.
module uyvbgr_convert
    import uyvbgr_pkg::*;
#(
    parameter int unsigned COEF_FRAC_BITS = 12
) (
    input  yuv_t yuv,
    output bgr_t bgr
);

    localparam int unsigned ACC_W = COEF_FRAC_BITS + 11;
    localparam int unsigned Q_W   = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] K_Y  =
        ACC_W'(((MILLI_Y  << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [ACC_W-1:0] K_VR =
        ACC_W'(((MILLI_VR << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [ACC_W-1:0] K_VG =
        ACC_W'(((MILLI_VG << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [ACC_W-1:0] K_UG =
        ACC_W'(((MILLI_UG << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [ACC_W-1:0] K_UB =
        ACC_W'(((MILLI_UB << COEF_FRAC_BITS) + 500) / 1000);

    logic signed [CHAN_W:0]  y_s, u_s, v_s;
    logic signed [ACC_W-1:0] y_x, u_x, v_x;
    logic signed [ACC_W-1:0] acc_b, acc_g, acc_r;

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [ACC_W-1:0] acc);
        logic [Q_W-1:0] q;
        q = acc[ACC_W-1:COEF_FRAC_BITS];
        if (acc[ACC_W-1]) begin
            return '0;
        end else if (|q[Q_W-1:CHAN_W]) begin
            return CHAN_MAX;
        end else begin
            return q[CHAN_W-1:0];
        end
    endfunction

    always_comb begin
        y_s = $signed({1'b0, yuv.y} - Y_OFFSET);
        u_s = $signed({1'b0, yuv.u} - UV_OFFSET);
        v_s = $signed({1'b0, yuv.v} - UV_OFFSET);
        y_x = ACC_W'(y_s);
        u_x = ACC_W'(u_s);
        v_x = ACC_W'(v_s);
        acc_b = K_Y * y_x + K_UB * u_x;
        acc_g = K_Y * y_x - K_UG * u_x - K_VG * v_x;
        acc_r = K_Y * y_x + K_VR * v_x;
        bgr.blue  = clamp_chan(acc_b);
        bgr.green = clamp_chan(acc_g);
        bgr.red   = clamp_chan(acc_r);
    end

endmodule

// ----- rtl/uyvy_downscale_to_bgr_unit.sv -----
// Top level: UYVY line-pair downscale to BGR pixels.
//
//  channel | dir | tdata                                 | tuser
//  s_      | in  | [31:0] upper_word, [63:32] lower_word  | [0] line_start
//  m_      | out | [7:0] blue, [15:8] green, [23:16] red  | -
//
// One input word per cycle while s_tready is high.
// Stage 1 registers the four-sample averages, stage 2 the BGR result.
// Groups of three words give two pixels; the first word of a group gives none.
// aresetn clears the held words, the grouping phase and both valid flags.
// A stall on m_ backs up through both stages to s_tready.
module uyvy_downscale_to_bgr_unit
    import uyvbgr_pkg::*;
#(
    parameter int unsigned COEF_FRAC_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // upper_word, lower_word
    input  logic [0:0]  s_tuser,   // line_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // blue, green, red
);

    logic [WORD_W-1:0] held_upper_reg, held_upper_next;
    logic [WORD_W-1:0] held_lower_reg, held_lower_next;
    phase_t            phase_reg, phase_next;
    logic              st_valid_reg, st_valid_next;
    yuv_t              st_yuv_reg, st_yuv_next;
    logic              out_valid_reg, out_valid_next;
    bgr_t              out_bgr_reg, out_bgr_next;

    logic [WORD_W-1:0] up_word, lo_word;
    logic              s_acc, st_ready, out_ready;
    phase_t            eff_phase;
    logic              pix_valid;
    logic [1:0]        ylane;
    yuv_t              avg;
    bgr_t              conv_bgr;

    function automatic logic [CHAN_W-1:0] lane(input logic [WORD_W-1:0] w,
                                               input logic [1:0] pos);
        return w[pos*CHAN_W +: CHAN_W];
    endfunction

    function automatic logic [CHAN_W-1:0] avg4(input logic [CHAN_W-1:0] a, b, c, d);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
        return s[SUM_W-1:2];
    endfunction

    assign up_word   = s_tdata[WORD_W-1:0];
    assign lo_word   = s_tdata[2*WORD_W-1:WORD_W];
    assign out_ready = !out_valid_reg || m_tready;
    assign st_ready  = !st_valid_reg || out_ready;
    assign s_tready  = st_ready;
    assign s_acc     = s_tvalid && st_ready;

    uyvbgr_convert #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_convert (
        .yuv(st_yuv_reg),
        .bgr(conv_bgr)
    );

    always_comb begin
        eff_phase = s_tuser[0] ? PH_M0 : phase_reg;
        unique case (eff_phase)
            PH_M1: begin
                pix_valid  = 1'b1;
                ylane      = 2'(LANE_Y0);
                phase_next = PH_M2;
            end
            PH_M2: begin
                pix_valid  = 1'b1;
                ylane      = 2'(LANE_Y1);
                phase_next = PH_M0;
            end
            default: begin
                pix_valid  = 1'b0;
                ylane      = 2'(LANE_Y0);
                phase_next = PH_M1;
            end
        endcase

        avg.u = avg4(lane(held_upper_reg, 2'(LANE_U)), lane(held_lower_reg, 2'(LANE_U)),
                     lane(up_word, 2'(LANE_U)), lane(lo_word, 2'(LANE_U)));
        avg.v = avg4(lane(held_upper_reg, 2'(LANE_V)), lane(held_lower_reg, 2'(LANE_V)),
                     lane(up_word, 2'(LANE_V)), lane(lo_word, 2'(LANE_V)));
        avg.y = avg4(lane(held_upper_reg, ylane), lane(held_lower_reg, ylane),
                     lane(up_word, ylane), lane(lo_word, ylane));

        held_upper_next = held_upper_reg;
        held_lower_next = held_lower_reg;
        st_valid_next   = st_valid_reg;
        st_yuv_next     = st_yuv_reg;
        if (s_acc) begin
            held_upper_next = up_word;
            held_lower_next = lo_word;
            st_valid_next   = pix_valid;
            st_yuv_next     = avg;
        end else begin
            if (out_ready) begin
                st_valid_next = 1'b0;
            end
            phase_next = phase_reg;
        end

        out_valid_next = out_valid_reg;
        out_bgr_next   = out_bgr_reg;
        if (out_ready) begin
            out_valid_next = st_valid_reg;
            out_bgr_next   = conv_bgr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_upper_reg <= '0;
            held_lower_reg <= '0;
            phase_reg      <= PH_M0;
            st_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            held_upper_reg <= held_upper_next;
            held_lower_reg <= held_lower_next;
            phase_reg      <= phase_next;
            st_valid_reg   <= st_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_yuv_reg  <= st_yuv_next;
        out_bgr_reg <= out_bgr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bgr_reg;

    a_first_word_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser[0] || phase_reg == PH_M0) |=> !st_valid_reg)
        else $error("first word of a group produced a pixel");

    a_line_start_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser[0] |=> phase_reg == PH_M1)
        else $error("line start did not restart grouping");

    a_mid_word_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !s_tuser[0] && (phase_reg == PH_M1 || phase_reg == PH_M2)
        |=> st_valid_reg)
        else $error("group word lost its pixel");

    a_out_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(st_valid_reg))
        else $error("output word without a staged pixel");

endmodule
